// ===== rtl/pmsa_pkg.sv =====
package pmsa_pkg;

   localparam int unsigned QTY_COUNT     = 5;
   localparam int unsigned QTY_IDX_W     = 3;
   localparam int unsigned SUM_W         = 32;
   localparam int unsigned SQ_W          = 48;
   localparam int unsigned HOMO_SUM_W    = 26;
   localparam int unsigned HOMO_SQ_W     = 36;
   localparam int unsigned DIV_W         = 64;
   localparam int unsigned DEN_W         = 26;
   localparam int unsigned ROOT_W        = 32;
   localparam int unsigned RES_W         = 24;
   localparam int unsigned REQ_DATA_W    = 96;
   localparam int unsigned RSP_DATA_W    = 176;
   localparam int unsigned CSR_INDEX_W   = 2;
   localparam int unsigned CSR_DATA_W    = 10;
   localparam int unsigned DEFAULT_MAX_POPULATION = 65535;

   typedef enum logic [1:0] {
      OP_ACCUMULATE = 2'd0,
      OP_FINALIZE   = 2'd1,
      OP_CLEAR      = 2'd2,
      OP_UNUSED     = 2'd3
   } opcode_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_TRAIT_MODE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOCUS_COUNT = 2'd1;

   localparam logic [QTY_IDX_W-1:0] Q_MUTATION   = 3'd0;
   localparam logic [QTY_IDX_W-1:0] Q_FITNESS    = 3'd1;
   localparam logic [QTY_IDX_W-1:0] Q_HOMOZYGOUS = 3'd2;
   localparam logic [QTY_IDX_W-1:0] Q_EMIGRATION = 3'd3;
   localparam logic [QTY_IDX_W-1:0] Q_DISTANCE   = 3'd4;

endpackage

// ===== rtl/population_mean_sd_accumulator.sv =====
// Accumulate beat: accepted, then the five quantities pass in turn through the single
// 32x32 multiplier. Clear beat: sums cleared on acceptance. Unused opcode: no result.
// Finalize beat: each selected quantity goes through the 64-step restoring divider
// (three or four passes per quantity, four for homozygosity) and the 32-step square
// root. One item at a time; a finished result waits in the output register. Reset
// (synchronous) clears all sums, sets trait_mode to 0 and locus_count to 1.
module population_mean_sd_accumulator
   import pmsa_pkg::*;
#(
   parameter int unsigned MAX_POPULATION = DEFAULT_MAX_POPULATION
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // mutation_count[15:0], fitness[31:16], homozygous_loci[41:32],
   // emigration_prob[57:42], dispersal_distance[73:58], population_size[89:74]
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // opcode[1:0]
   input  logic [1:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // mean_mutations[23:0], sd_mutations[47:24], mean_fitness[63:48],
   // sd_fitness[79:64], mean_homozygosity[95:80], sd_homozygosity[111:96],
   // mean_emigration[127:112], sd_emigration[143:128], mean_distance[159:144],
   // sd_distance[175:160]
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // empty_error[0]
   output logic                   rsp_tuser,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_ACC, ST_NL, ST_LL, ST_SQ, ST_TDIV, ST_MDIV, ST_VDIV, ST_ADIV,
      ST_ROOT, ST_EMIT
   } state_type;

   localparam logic [6:0]  DIV_STEPS  = 7'(DIV_W);
   localparam logic [5:0]  ROOT_STEPS = 6'(ROOT_W);
   localparam logic [15:0] N_MAX      = 16'(MAX_POPULATION);
   localparam logic [DIV_W-1:0] A_MAX = {9'd0, {55{1'b1}}};

   state_type state_ff, state_in;

   logic [1:0]  trait_mode_ff;
   logic [9:0]  locus_count_ff;

   logic [15:0] m_ff, f_ff, e_ff, dd_ff;
   logic [9:0]  h_ff;
   logic [15:0] n_ff;
   logic [DEN_W-1:0] nl_ff;
   logic [19:0] ll_ff;
   logic [QTY_IDX_W-1:0] qsel_ff;
   logic [SQ_W-1:0] d_ff;

   logic [SUM_W-1:0] sum_ff [QTY_COUNT];
   logic [SQ_W-1:0]  sq_ff  [QTY_COUNT];
   logic [RES_W-1:0] mean_ff [QTY_COUNT];
   logic [RES_W-1:0] sd_ff   [QTY_COUNT];
   logic             err_ff;

   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_user_ff;

   // Divider and square-root unit.
   logic             div_start;
   logic [DIV_W-1:0] div_num_in;
   logic [DEN_W-1:0] div_den_in;
   logic [DIV_W-1:0] div_num_ff;
   logic [DEN_W-1:0] div_den_ff;
   logic [DEN_W-1:0] div_rem_ff;
   logic [6:0]       div_cnt_ff;
   logic             div_busy;
   logic [DEN_W:0]   div_shift;
   logic             div_ge;
   logic [DEN_W:0]   div_diff;

   logic              root_start;
   logic [DIV_W-1:0]  root_x_ff;
   logic [ROOT_W+1:0] root_r_ff;
   logic [ROOT_W-1:0] root_q_ff;
   logic [5:0]        root_cnt_ff;
   logic              root_busy;
   logic [ROOT_W+1:0] root_shift, root_trial;

   // Shared multiplier.
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;

   logic [15:0]      sel_x;
   logic             sel_en;
   logic             sel_last;
   logic [SUM_W-1:0] acc_sum;
   logic [SQ_W-1:0]  acc_sq;
   logic [15:0]      req_n;
   logic [15:0]      req_n_clamped;
   logic [9:0]       locus_eff;
   logic [SQ_W-1:0]  cur_sq;
   logic [SUM_W-1:0] cur_sum;
   logic [DIV_W-1:0] mean_num;
   logic [DEN_W-1:0] mean_den;
   logic [DIV_W-1:0] var_num;
   logic [DIV_W-1:0] a_val;
   logic [RES_W-1:0] quot_sat;
   logic [RES_W-1:0] root_sat;
   logic             is_mut;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign req_n         = req_tdata[89:74];
   assign req_n_clamped = (req_n > N_MAX) ? N_MAX : req_n;
   assign locus_eff     = (locus_count_ff == 10'd0) ? 10'd1 : locus_count_ff;

   assign cur_sum = sum_ff[qsel_ff];
   assign cur_sq  = sq_ff[qsel_ff];
   assign is_mut  = (qsel_ff == Q_MUTATION);

   always_comb begin
      case (qsel_ff)
         Q_MUTATION:   begin sel_x = m_ff;          sel_en = 1'b1; end
         Q_FITNESS:    begin sel_x = f_ff;          sel_en = 1'b1; end
         Q_HOMOZYGOUS: begin sel_x = {6'd0, h_ff};  sel_en = 1'b1; end
         Q_EMIGRATION: begin sel_x = e_ff;          sel_en = trait_mode_ff[0]; end
         Q_DISTANCE:   begin sel_x = dd_ff;         sel_en = trait_mode_ff[1]; end
         default:      begin sel_x = 16'd0;         sel_en = 1'b0; end
      endcase
   end
   assign sel_last = (qsel_ff == Q_DISTANCE);

   always_comb begin
      case (state_ff)
         ST_ACC:  begin mul_a = {16'd0, sel_x};    mul_b = {16'd0, sel_x}; end
         ST_NL:   begin mul_a = {16'd0, n_ff};     mul_b = {22'd0, locus_eff}; end
         ST_LL:   begin mul_a = {22'd0, locus_eff}; mul_b = {22'd0, locus_eff}; end
         ST_SQ:   begin mul_a = cur_sum;           mul_b = cur_sum; end
         default: begin mul_a = 32'd0;             mul_b = 32'd0; end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // Sums wrap at their own widths; the homozygous pair is narrower.
   always_comb begin
      acc_sum = cur_sum + {16'd0, sel_x};
      acc_sq  = cur_sq + mul_p[SQ_W-1:0];
      if (qsel_ff == Q_HOMOZYGOUS) begin
         acc_sum[SUM_W-1:HOMO_SUM_W] = '0;
         acc_sq[SQ_W-1:HOMO_SQ_W]    = '0;
      end
   end

   always_comb begin
      case (qsel_ff)
         Q_MUTATION: begin
            mean_num = {24'd0, cur_sum, 8'd0};
            mean_den = {10'd0, n_ff};
            var_num  = {d_ff, 16'd0};
         end
         Q_HOMOZYGOUS: begin
            mean_num = {16'd0, cur_sum, 16'd0};
            mean_den = nl_ff;
            var_num  = {d_ff[39:0], 24'd0};
         end
         default: begin
            mean_num = {32'd0, cur_sum};
            mean_den = {10'd0, n_ff};
            var_num  = {16'd0, d_ff};
         end
      endcase
   end

   assign a_val = (div_num_ff > A_MAX) ? A_MAX : div_num_ff;

   always_comb begin
      if (is_mut) begin
         quot_sat = (div_num_ff > {40'd0, {RES_W{1'b1}}}) ? {RES_W{1'b1}}
                                                           : div_num_ff[RES_W-1:0];
         root_sat = (root_q_ff > {8'd0, {RES_W{1'b1}}}) ? {RES_W{1'b1}}
                                                         : root_q_ff[RES_W-1:0];
      end else begin
         quot_sat = (div_num_ff > 64'h0000_0000_0000_FFFF) ? 24'h00FFFF
                                                            : {8'd0, div_num_ff[15:0]};
         root_sat = (root_q_ff > 32'h0000_FFFF) ? 24'h00FFFF : {8'd0, root_q_ff[15:0]};
      end
   end

   always_comb begin
      state_in   = state_ff;
      div_start  = 1'b0;
      div_num_in = mul_p;
      div_den_in = {10'd0, n_ff};
      root_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (opcode_type'(req_tuser))
                  OP_ACCUMULATE: state_in = ST_ACC;
                  OP_FINALIZE:   state_in = (req_n == 16'd0) ? ST_EMIT : ST_NL;
                  default:       state_in = ST_IDLE;
               endcase
            end
         end
         ST_ACC:  if (sel_last) state_in = ST_IDLE;
         ST_NL:   state_in = ST_LL;
         ST_LL:   state_in = ST_SQ;
         ST_SQ: begin
            if (sel_en) begin
               div_start = 1'b1;
               state_in  = ST_TDIV;
            end else if (sel_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_TDIV: begin
            if (!div_busy) begin
               div_start  = 1'b1;
               div_num_in = mean_num;
               div_den_in = mean_den;
               state_in   = ST_MDIV;
            end
         end
         ST_MDIV: begin
            if (!div_busy) begin
               div_start  = 1'b1;
               div_num_in = var_num;
               state_in   = ST_VDIV;
            end
         end
         ST_VDIV: begin
            if (!div_busy) begin
               if (qsel_ff == Q_HOMOZYGOUS) begin
                  div_start  = 1'b1;
                  div_num_in = {a_val[DIV_W-9:0], 8'd0};
                  div_den_in = {6'd0, ll_ff};
                  state_in   = ST_ADIV;
               end else begin
                  root_start = 1'b1;
                  state_in   = ST_ROOT;
               end
            end
         end
         ST_ADIV: begin
            if (!div_busy) begin
               root_start = 1'b1;
               state_in   = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (!root_busy && !root_start) state_in = sel_last ? ST_EMIT : ST_SQ;
         end
         ST_EMIT: if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Root started on entry; a one-cycle guard keeps the done test honest.
   logic root_wait_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         trait_mode_ff  <= 2'd0;
         locus_count_ff <= 10'd1;
         qsel_ff        <= Q_MUTATION;
         rsp_valid_ff   <= 1'b0;
         err_ff         <= 1'b0;
         root_wait_ff   <= 1'b0;
         for (int i = 0; i < QTY_COUNT; i++) begin
            sum_ff[i] <= '0;
            sq_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         root_wait_ff <= root_start;
         if (rsp_valid_ff && rsp_tready && state_ff != ST_EMIT) rsp_valid_ff <= 1'b0;
         if (csr_valid) begin
            if (csr_index == CSR_TRAIT_MODE)  trait_mode_ff  <= csr_data[1:0];
            if (csr_index == CSR_LOCUS_COUNT) locus_count_ff <= csr_data;
         end
         case (state_ff)
            ST_IDLE: begin
               qsel_ff <= Q_MUTATION;
               if (req_tvalid) begin
                  m_ff  <= req_tdata[15:0];
                  f_ff  <= req_tdata[31:16];
                  h_ff  <= req_tdata[41:32];
                  e_ff  <= req_tdata[57:42];
                  dd_ff <= req_tdata[73:58];
                  n_ff  <= req_n_clamped;
                  if (opcode_type'(req_tuser) == OP_CLEAR) begin
                     for (int i = 0; i < QTY_COUNT; i++) begin
                        sum_ff[i] <= '0;
                        sq_ff[i]  <= '0;
                     end
                  end
                  if (opcode_type'(req_tuser) == OP_FINALIZE) begin
                     err_ff <= (req_n == 16'd0);
                     for (int i = 0; i < QTY_COUNT; i++) begin
                        mean_ff[i] <= '0;
                        sd_ff[i]   <= '0;
                     end
                  end
               end
            end
            ST_ACC: begin
               if (sel_en) begin
                  sum_ff[qsel_ff] <= acc_sum;
                  sq_ff[qsel_ff]  <= acc_sq;
               end
               if (!sel_last) qsel_ff <= qsel_ff + 3'd1;
            end
            ST_NL: nl_ff <= mul_p[DEN_W-1:0];
            ST_LL: ll_ff <= mul_p[19:0];
            ST_SQ: if (!sel_en && !sel_last) qsel_ff <= qsel_ff + 3'd1;
            ST_TDIV: begin
               if (!div_busy) begin
                  d_ff <= ({16'd0, cur_sq} > div_num_ff)
                          ? cur_sq - div_num_ff[SQ_W-1:0] : '0;
               end
            end
            ST_MDIV: if (!div_busy) mean_ff[qsel_ff] <= quot_sat;
            ST_ROOT: begin
               if (!root_busy && !root_wait_ff) begin
                  sd_ff[qsel_ff] <= root_sat;
                  if (!sel_last) qsel_ff <= qsel_ff + 3'd1;
               end
            end
            ST_EMIT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_user_ff  <= err_ff;
                  rsp_data_ff  <= {sd_ff[4][15:0], mean_ff[4][15:0],
                                   sd_ff[3][15:0], mean_ff[3][15:0],
                                   sd_ff[2][15:0], mean_ff[2][15:0],
                                   sd_ff[1][15:0], mean_ff[1][15:0],
                                   sd_ff[0], mean_ff[0]};
               end
            end
            default: ;
         endcase
      end
   end

   // Restoring divider, one quotient bit a cycle; quotient ends in div_num_ff.
   assign div_busy  = (div_cnt_ff != 7'd0);
   assign div_shift = {div_rem_ff, div_num_ff[DIV_W-1]};
   assign div_ge    = (div_shift >= {1'b0, div_den_ff});
   assign div_diff  = div_shift - {1'b0, div_den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= 7'd0;
      end else if (div_start) begin
         div_num_ff <= div_num_in;
         div_den_ff <= div_den_in;
         div_rem_ff <= '0;
         div_cnt_ff <= DIV_STEPS;
      end else if (div_busy) begin
         div_rem_ff <= div_ge ? div_diff[DEN_W-1:0] : div_shift[DEN_W-1:0];
         div_num_ff <= {div_num_ff[DIV_W-2:0], div_ge};
         div_cnt_ff <= div_cnt_ff - 7'd1;
      end
   end

   // Digit-by-digit square root, two radicand bits a cycle.
   assign root_busy  = (root_cnt_ff != 6'd0) || root_wait_ff;
   assign root_shift = {root_r_ff[ROOT_W-1:0], root_x_ff[DIV_W-1:DIV_W-2]};
   assign root_trial = {root_q_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (reset) begin
         root_cnt_ff <= 6'd0;
      end else if (root_start) begin
         root_x_ff   <= div_num_ff;
         root_r_ff   <= '0;
         root_q_ff   <= '0;
         root_cnt_ff <= ROOT_STEPS;
      end else if (root_cnt_ff != 6'd0) begin
         root_x_ff <= {root_x_ff[DIV_W-3:0], 2'b00};
         if (root_shift >= root_trial) begin
            root_r_ff <= root_shift - root_trial;
            root_q_ff <= {root_q_ff[ROOT_W-2:0], 1'b1};
         end else begin
            root_r_ff <= root_shift;
            root_q_ff <= {root_q_ff[ROOT_W-2:0], 1'b0};
         end
         root_cnt_ff <= root_cnt_ff - 6'd1;
      end
   end

endmodule
